@@ rtl/stid_pkg.sv @@
// Shared types and codes for the sorted table insert/delete unit.
`timescale 1ns / 1ps

package stid_pkg;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Input item
    typedef struct packed {
        logic               command;
        logic signed [31:0] key_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] smallest_value;
        logic signed [31:0] largest_value;
    } t_out_item;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic               ins_en;
        logic               del_en;
        logic signed [31:0] key;
    } t_cell_ctrl;

endpackage

@@ rtl/stid_cell.sv @@
// One cell of the sorted table: holds one entry, compares it with the key, shifts locally.
`timescale 1ns / 1ps

module stid_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  stid_pkg::t_cell_ctrl  i_ctrl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_left_lt,
    input  logic signed [31:0]    i_left_value,
    input  logic signed [31:0]    i_right_value,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic signed [31:0]    o_value,
    output logic signed [31:0]    o_last_value
);
    import stid_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               occupied;
    logic               is_last;

    // Occupancy and comparisons against the broadcast key
    assign occupied = (IDX_C < i_count);
    assign is_last  = (NEXT_C == i_count);
    assign o_lt     = occupied && (r_value < i_ctrl.key);
    assign o_eq     = occupied && (r_value == i_ctrl.key);
    assign o_value  = r_value;
    assign o_last_value = is_last ? r_value : 32'sd0;

    // Insert opens a gap at the first cell not below the key; delete closes it
    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins_en && !o_lt) begin
            n_value = i_left_lt ? i_ctrl.key : i_left_value;
        end else if (i_ctrl.del_en && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/sorted_table_insert_delete_unit.sv @@
// Top level of the sorted table insert/delete unit: cell chain, count and result register.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in a chain of
// cells. An insert places the key ahead of equal or larger entries; a delete
// removes the first equal entry. Each item yields one result with status, the
// new entry count (taken modulo 32) and the smallest and largest entries (zero
// when empty). At acceptance every cell compares with the key and shifts at
// once; then, in the calculation state, the end entries are gathered from the
// chain into the output register. The input is not ready while the end entries
// are being gathered, nor while a finished result cannot yet move into the
// output register. The table is empty after reset.
module sorted_table_insert_delete_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  stid_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output stid_pkg::t_out_item  o_out_item
);
    import stid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);

    t_cell_ctrl         cell_ctrl;
    logic               lt    [CAPACITY];
    logic               eq    [CAPACITY];
    logic signed [31:0] value [CAPACITY];
    logic signed [31:0] last_value [CAPACITY];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_calc;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          result;
    logic               accept;
    logic               found;
    logic               full;
    logic [CNT_W+4:0]   count_ext;
    logic signed [31:0] largest;

    assign o_in_ready  = !r_calc;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Match and full detection
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | eq[i];
        end
    end
    assign full = (r_count == FULL_C);

    // Controls broadcast to the cells
    assign cell_ctrl.key    = i_in_item.key_value;
    assign cell_ctrl.ins_en = accept && (i_in_item.command == CMD_INSERT) && !full;
    assign cell_ctrl.del_en = accept && (i_in_item.command == CMD_DELETE) && found;

    // Count and status for the item being accepted
    always_comb begin
        n_count  = r_count;
        n_status = STATUS_DONE;
        if (i_in_item.command == CMD_INSERT) begin
            if (full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (found) begin
                n_count = r_count - 1'b1;
            end else begin
                n_status = STATUS_NOT_FOUND;
            end
        end
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic               left_lt;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        if (g == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = value[g];
        end else begin : g_mid
            assign left_lt    = lt[g-1];
            assign left_value = value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_value = value[g];
        end else begin : g_inner
            assign right_value = value[g+1];
        end

        stid_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_count       (r_count),
            .i_left_lt     (left_lt),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_lt          (lt[g]),
            .o_eq          (eq[g]),
            .o_value       (value[g]),
            .o_last_value  (last_value[g])
        );
    end

    // Gather the end entries from the updated chain
    always_comb begin
        largest = 32'sd0;
        for (int i = 0; i < CAPACITY; i++) begin
            largest = largest | last_value[i];
        end
    end
    assign count_ext = {5'd0, r_count};
    always_comb begin
        result.status         = r_status;
        result.entry_count    = count_ext[4:0];
        result.smallest_value = (r_count != '0) ? value[0] : 32'sd0;
        result.largest_value  = largest;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_calc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_calc  <= 1'b1;
            end else if (r_calc && (!r_out_valid || i_out_ready)) begin
                r_calc  <= 1'b0;
            end
            if (r_calc && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (r_calc && (!r_out_valid || i_out_ready)) begin
            r_out_item <= result;
        end
    end

endmodule
